@@ hw/rtl/clcd_pkg.sv @@
package clcd_pkg;

    // One queued request, already classified by the front end
    typedef struct packed {
        logic       is_write;     // 1 = byte write request, 0 = millisecond tick
        logic [7:0] byte_value;
        logic       is_character;
    } clcd_item_t;

    // Power-up timing in ticks
    localparam logic [6:0] POWERUP_MS     = 7'd100;
    localparam logic [6:0] HIGH_GAP_MS    = 7'd2;
    localparam logic [6:0] LOW_GAP_MS     = 7'd5;
    localparam logic [3:0] INIT_LAST_STEP = 4'd13;

    // Nibble sent at each step of the power-up sequence
    function automatic logic [3:0] init_nibble(input logic [3:0] step);
        logic [3:0] nib;
        case (step)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3, 4'd4:       nib = 4'h2;
            4'd5, 4'd7:       nib = 4'h8;
            4'd9:             nib = 4'h1;
            4'd11:            nib = 4'h6;
            4'd13:            nib = 4'hF;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

    // Wait after each power-up nibble, in ticks
    function automatic logic [6:0] init_gap(input logic [3:0] step);
        logic [6:0] gap;
        case (step)
            4'd0, 4'd1:                          gap = 7'd25;
            4'd4, 4'd6, 4'd8, 4'd10, 4'd12:      gap = HIGH_GAP_MS;
            default:                             gap = LOW_GAP_MS;
        endcase
        return gap;
    endfunction

endpackage

@@ hw/rtl/char_lcd_4bit_write_sequencer.sv @@
// Channel   Direction  Ports
// input     in         s_valid, s_ready, s_mode, s_byte_value, s_is_character
// result    out        m_valid, m_ready, m_enable_pin, m_select_pin,
//                      m_read_write_pin, m_bus_nibble, m_busy_res, m_accepted
//
// One request per clock while the queue has room: an accepted request enters a
// two-entry queue, and the sequencer runs it once the result register is free or
// draining; m_valid is registered.
// Reset (aresetn low, synchronous) starts the 100-tick power-up wait.
// The queue lets intake continue while a result waits for m_ready;
// input stalls only when the queue is full.
module char_lcd_4bit_write_sequencer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [7:0] s_byte_value,
    input  logic       s_is_character,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_enable_pin,
    output logic       m_select_pin,
    output logic       m_read_write_pin,
    output logic [3:0] m_bus_nibble,
    output logic       m_busy_res,
    output logic       m_accepted
);

    logic                 q_valid;
    logic                 q_pop;
    clcd_pkg::clcd_item_t q_item;

    // Intake and queue
    clcd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_byte_value   (s_byte_value),
        .s_is_character (s_is_character),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item)
    );

    // Sequencer and result register
    clcd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_enable_pin     (m_enable_pin),
        .m_select_pin     (m_select_pin),
        .m_read_write_pin (m_read_write_pin),
        .m_bus_nibble     (m_bus_nibble),
        .m_busy_res       (m_busy_res),
        .m_accepted       (m_accepted)
    );

endmodule

@@ hw/rtl/clcd_front.sv @@
module clcd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [7:0]          s_byte_value,
    input  logic                s_is_character,
    output logic                q_valid,
    input  logic                q_pop,
    output clcd_pkg::clcd_item_t q_item
);

    // Two-entry queue between intake and sequencer
    clcd_pkg::clcd_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    clcd_pkg::clcd_item_t item_in;

    // Classify the incoming request
    always_comb begin
        item_in.is_write     = s_mode;
        item_in.byte_value   = s_byte_value;
        item_in.is_character = s_is_character;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

@@ hw/rtl/clcd_back.sv @@
module clcd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  clcd_pkg::clcd_item_t q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_enable_pin,
    output logic                 m_select_pin,
    output logic                 m_read_write_pin,
    output logic [3:0]           m_bus_nibble,
    output logic                 m_busy_res,
    output logic                 m_accepted
);

    typedef enum logic [5:0] {
        PH_POWER_WAIT  = 6'b000001,
        PH_INIT_STROBE = 6'b000010,
        PH_INIT_GAP    = 6'b000100,
        PH_IDLE        = 6'b001000,
        PH_BYTE_STROBE = 6'b010000,
        PH_BYTE_GAP    = 6'b100000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] step_reg, step_next;
    logic [6:0] wait_reg, wait_next;
    logic [7:0] held_reg, held_next;
    logic       e_reg, e_next;
    logic       rs_reg, rs_next;
    logic [3:0] data_reg, data_next;
    logic       acc_next;
    logic       idle_now, idle_after;
    logic [6:0] wait_dec;
    logic       take;
    logic       m_valid_reg;
    logic       busy_out_reg, acc_out_reg;

    // Unknown codes behave as idle
    function automatic logic phase_idle(input phase_t p);
        logic r;
        case (p)
            PH_POWER_WAIT, PH_INIT_STROBE, PH_INIT_GAP,
            PH_BYTE_STROBE, PH_BYTE_GAP: r = 1'b0;
            default:                     r = 1'b1;
        endcase
        return r;
    endfunction

    // Take the next request whenever the output register is free or draining
    assign take     = q_valid && (!m_valid_reg || m_ready);
    assign q_pop    = take;
    assign idle_now = phase_idle(phase_reg);
    assign wait_dec = (wait_reg != 7'd0) ? (wait_reg - 7'd1) : wait_reg;

    // Sequencer step for one request
    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        wait_next  = wait_reg;
        held_next  = held_reg;
        e_next     = e_reg;
        rs_next    = rs_reg;
        data_next  = data_reg;
        acc_next   = 1'b0;
        if (q_item.is_write) begin
            // byte write: accepted only when idle (dropped otherwise), high nibble strobes at once
            if (idle_now) begin
                held_next  = q_item.byte_value;
                rs_next    = q_item.is_character;
                step_next  = 4'd0;
                e_next     = 1'b1;
                data_next  = q_item.byte_value[7:4];
                wait_next  = 7'd1;
                phase_next = PH_BYTE_STROBE;
                acc_next   = 1'b1;
            end
        end else if (!idle_now) begin
            wait_next = wait_dec;
            if (wait_dec == 7'd0) begin
                case (phase_reg)
                    PH_POWER_WAIT: begin
                        rs_next    = 1'b0;
                        step_next  = 4'd0;
                        e_next     = 1'b1;
                        data_next  = clcd_pkg::init_nibble(4'd0);
                        wait_next  = 7'd1;
                        phase_next = PH_INIT_STROBE;
                    end
                    PH_INIT_STROBE: begin
                        e_next     = 1'b0;
                        wait_next  = clcd_pkg::init_gap(step_reg);
                        phase_next = PH_INIT_GAP;
                    end
                    PH_INIT_GAP: begin
                        if (step_reg >= clcd_pkg::INIT_LAST_STEP) begin
                            rs_next    = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            step_next  = step_reg + 4'd1;
                            e_next     = 1'b1;
                            data_next  = clcd_pkg::init_nibble(step_reg + 4'd1);
                            wait_next  = 7'd1;
                            phase_next = PH_INIT_STROBE;
                        end
                    end
                    PH_BYTE_STROBE: begin
                        e_next     = 1'b0;
                        wait_next  = (step_reg == 4'd0) ? clcd_pkg::HIGH_GAP_MS
                                                        : clcd_pkg::LOW_GAP_MS;
                        phase_next = PH_BYTE_GAP;
                    end
                    PH_BYTE_GAP: begin
                        if (step_reg != 4'd0) begin
                            phase_next = PH_IDLE;
                        end else begin
                            step_next  = 4'd1;
                            e_next     = 1'b1;
                            data_next  = held_reg[3:0];
                            wait_next  = 7'd1;
                            phase_next = PH_BYTE_STROBE;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    assign idle_after = phase_idle(phase_next);

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_POWER_WAIT;
            step_reg     <= 4'd0;
            wait_reg     <= clcd_pkg::POWERUP_MS;
            held_reg     <= 8'd0;
            e_reg        <= 1'b0;
            rs_reg       <= 1'b0;
            data_reg     <= 4'd0;
            m_valid_reg  <= 1'b0;
            busy_out_reg <= 1'b0;
            acc_out_reg  <= 1'b0;
        end else if (take) begin
            phase_reg    <= phase_next;
            step_reg     <= step_next;
            wait_reg     <= wait_next;
            held_reg     <= held_next;
            e_reg        <= e_next;
            rs_reg       <= rs_next;
            data_reg     <= data_next;
            m_valid_reg  <= 1'b1;
            busy_out_reg <= !idle_after;
            acc_out_reg  <= acc_next;
        end else if (m_ready) begin
            m_valid_reg  <= 1'b0;
        end
    end

    // Pin levels shown are those left by the last request
    assign m_valid          = m_valid_reg;
    assign m_enable_pin     = e_reg;
    assign m_select_pin     = rs_reg;
    assign m_read_write_pin = 1'b0;
    assign m_bus_nibble     = data_reg;
    assign m_busy_res       = busy_out_reg;
    assign m_accepted       = acc_out_reg;

endmodule
